/* rtl/descriptor_chain_allocator_macros.svh */
// Assertion helpers for the descriptor chain allocator.
// Each expects clk and arst_n in scope.
`ifndef DESCRIPTOR_CHAIN_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_CHAIN_ALLOCATOR_MACROS_SVH

// Consequent in the same cycle.
`define DCA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the following cycle.
`define DCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dca_pkg.sv */
package dca_pkg;

	localparam int QUEUE_MAX_DEF = 256;
	localparam int SLOT_W = 8;
	localparam int QS_W = 9;
	localparam logic [15:0] END_MARK = 16'hffff;
	localparam logic [15:0] DESC_NEXT = 16'h0001;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RECLAIM = 2'd1,
		MODE_QUERY   = 2'd2,
		MODE_SET     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic [15:0]       wr_next;
		logic [15:0]       wr_flag;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] next;
		logic [15:0] flag;
	} mem_rd_t;

	typedef struct packed {
		logic            status;
		logic [7:0]      head;
		logic [15:0]     next;
		logic [15:0]     flags;
		logic [QS_W-1:0] free;
	} res_t;

endpackage

/* rtl/descriptor_chain_allocator.sv */
// Descriptor chain allocator: free list of split-ring descriptor slots.
// Request channel (in_valid/in_stall): mode, count, index, flags; one beat per
// request, accepted when in_valid is high and in_stall low. Result channel
// (out_valid/out_stall): status, head_index, next_index, flags_out, free_count;
// exactly one result beat per request, in request order.
// Configuration channel (cfg_valid/cfg_ready, data on queue_size) rebuilds the
// list at a new size; values that are not a power of two in range are dropped.
// The link and flag tables sit in synchronous memories with a registered read,
// and a walk visits one slot per cycle. A rejected request goes straight to
// its result; a query or set reads its one slot, an alloc of n slots walks n
// slots and a reclaim walks a chain of L slots. The next request is taken once
// the result is handed to the output register.
// Reset rebuilds the list at the maximum queue size at once, with no clearing
// pass: unwritten slots read as their initial links.
// A stalled result is held in the output register; one more request completes
// behind it and then in_stall stays high until the result beat is taken.
module descriptor_chain_allocator #(
	parameter int QUEUE_MAX = dca_pkg::QUEUE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [8:0]  count,
	input  logic [15:0] index,
	input  logic [15:0] flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  head_index,
	output logic [15:0] next_index,
	output logic [15:0] flags_out,
	output logic [8:0]  free_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  queue_size
);

	dca_pkg::mem_req_t mem_req;
	dca_pkg::mem_rd_t mem_rd;
	dca_pkg::res_t res;
	logic [dca_pkg::QS_W-1:0] qs;
	logic res_valid;
	logic res_take;
	logic out_valid_q;
	dca_pkg::res_t out_q;

	dca_ctrl #(
		.QUEUE_MAX(QUEUE_MAX)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.count(count),
		.index(index),
		.flags(flags),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(queue_size),
		.qs(qs),
		.mem_req(mem_req),
		.mem_rd(mem_rd),
		.res_valid(res_valid),
		.res(res),
		.res_take(res_take)
	);

	dca_mem #(
		.QUEUE_MAX(QUEUE_MAX)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.qs(qs),
		.req(mem_req),
		.rd(mem_rd)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign head_index = out_q.head;
	assign next_index = out_q.next;
	assign flags_out = out_q.flags;
	assign free_count = out_q.free;

endmodule

/* rtl/dca_mem.sv */
module dca_mem #(
	parameter int QUEUE_MAX = dca_pkg::QUEUE_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [dca_pkg::QS_W-1:0]  qs,
	input  dca_pkg::mem_req_t         req,
	output dca_pkg::mem_rd_t          rd
);

	localparam int DEPTH = (QUEUE_MAX < 256) ? QUEUE_MAX : 256;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [15:0] next_mem [DEPTH];
	logic [15:0] flag_mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	logic [15:0] next_s1;
	logic [15:0] flag_s1;
	logic [15:0] wnext_s1;
	logic [15:0] wflag_s1;
	logic [dca_pkg::SLOT_W-1:0] addr_s1;
	logic vld_s1;
	logic fwd_s1;
	logic [dca_pkg::QS_W-1:0] succ;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			next_mem[req.wr_addr[AW-1:0]] <= req.wr_next;
			flag_mem[req.wr_addr[AW-1:0]] <= req.wr_flag;
		end
		if (req.rd_en) begin
			next_s1 <= next_mem[req.rd_addr[AW-1:0]];
			flag_s1 <= flag_mem[req.rd_addr[AW-1:0]];
			wnext_s1 <= req.wr_next;
			wflag_s1 <= req.wr_flag;
			addr_s1 <= req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= vld_q[req.rd_addr[AW-1:0]];
				fwd_s1 <= req.wr_en && (req.wr_addr == req.rd_addr);
			end
		end
	end

	assign succ = {1'b0, addr_s1} + 9'd1;

	always_comb begin
		if (fwd_s1) begin
			rd.next = wnext_s1;
			rd.flag = wflag_s1;
		end else if (vld_s1) begin
			rd.next = next_s1;
			rd.flag = flag_s1;
		end else begin
			rd.next = (succ < qs) ? {7'd0, succ} : dca_pkg::END_MARK;
			rd.flag = 16'd0;
		end
	end

endmodule

/* rtl/dca_ctrl.sv */
`include "descriptor_chain_allocator_macros.svh"

module dca_ctrl #(
	parameter int QUEUE_MAX = dca_pkg::QUEUE_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                mode,
	input  logic [8:0]                count,
	input  logic [15:0]               index,
	input  logic [15:0]               flags,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [dca_pkg::QS_W-1:0]  cfg_data,
	output logic [dca_pkg::QS_W-1:0]  qs,
	output dca_pkg::mem_req_t         mem_req,
	input  dca_pkg::mem_rd_t          mem_rd,
	output logic                      res_valid,
	output dca_pkg::res_t             res,
	input  logic                      res_take
);

	localparam int DEPTH = (QUEUE_MAX < 256) ? QUEUE_MAX : 256;
	localparam logic [dca_pkg::QS_W-1:0] QS_RESET = dca_pkg::QS_W'(DEPTH);

	dca_pkg::state_t state_q, state_d;
	dca_pkg::mode_t mode_q, mode_d;
	logic [dca_pkg::QS_W-1:0] qs_q, qs_d;
	logic [15:0] free_head_q, free_head_d;
	logic [dca_pkg::QS_W-1:0] free_total_q, free_total_d;
	logic [8:0] remain_q, remain_d;
	logic [8:0] steps_q, steps_d;
	logic [15:0] flags_q, flags_d;
	logic [dca_pkg::SLOT_W-1:0] slot_q, slot_d;
	logic status_q, status_d;
	logic [7:0] head_q, head_d;
	logic [15:0] next_q, next_d;
	logic [15:0] fout_q, fout_d;

	logic accept;
	logic cfg_wr;
	logic cfg_ok;
	logic [dca_pkg::QS_W-1:0] mask;
	logic more;
	logic stop;
	logic [dca_pkg::SLOT_W-1:0] head_slot;
	logic [dca_pkg::SLOT_W-1:0] link_slot;

	function automatic logic [dca_pkg::SLOT_W-1:0] slot_of(
		input logic [15:0] v,
		input logic [dca_pkg::QS_W-1:0] m
	);
		logic [dca_pkg::QS_W-1:0] t;
		t = v[dca_pkg::QS_W-1:0] & m;
		return t[dca_pkg::SLOT_W-1:0];
	endfunction

	assign in_stall = (state_q != dca_pkg::ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == dca_pkg::ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign cfg_ok = (cfg_data >= 9'd2) && (cfg_data <= QS_RESET)
		&& ((cfg_data & (cfg_data - 9'd1)) == 9'd0);
	assign mask = qs_q - 9'd1;
	assign head_slot = slot_of(free_head_q, mask);
	assign link_slot = slot_of(mem_rd.next, mask);
	assign more = (remain_q != 9'd1);
	assign stop = !mem_rd.flag[0] || (mem_rd.next >= {7'd0, qs_q})
		|| ((steps_q + 9'd1) == qs_q);
	assign qs = qs_q;
	assign res_valid = (state_q == dca_pkg::ST_FINISH);
	assign res = '{status: status_q, head: head_q, next: next_q, flags: fout_q,
		free: free_total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dca_pkg::ST_IDLE;
			qs_q <= QS_RESET;
			free_head_q <= 16'd0;
			free_total_q <= QS_RESET;
		end else begin
			state_q <= state_d;
			qs_q <= qs_d;
			free_head_q <= free_head_d;
			free_total_q <= free_total_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		remain_q <= remain_d;
		steps_q <= steps_d;
		flags_q <= flags_d;
		slot_q <= slot_d;
		status_q <= status_d;
		head_q <= head_d;
		next_q <= next_d;
		fout_q <= fout_d;
	end

	always_comb begin
		state_d = state_q;
		mode_d = mode_q;
		qs_d = qs_q;
		free_head_d = free_head_q;
		free_total_d = free_total_q;
		remain_d = remain_q;
		steps_d = steps_q;
		flags_d = flags_q;
		slot_d = slot_q;
		status_d = status_q;
		head_d = head_q;
		next_d = next_q;
		fout_d = fout_q;
		mem_req = '0;
		mem_req.rd_addr = slot_q;
		mem_req.wr_addr = slot_q;

		unique case (state_q)
			dca_pkg::ST_IDLE: begin
				if (cfg_wr) begin
					if (cfg_ok) begin
						qs_d = cfg_data;
						free_head_d = 16'd0;
						free_total_d = cfg_data;
						mem_req.clear = 1'b1;
					end
				end else if (accept) begin
					mode_d = dca_pkg::mode_t'(mode);
					flags_d = flags;
					remain_d = count;
					steps_d = 9'd0;
					status_d = 1'b0;
					head_d = 8'd0;
					next_d = dca_pkg::END_MARK;
					fout_d = 16'd0;
					unique case (dca_pkg::mode_t'(mode)) inside
						dca_pkg::MODE_ALLOC: begin
							if ((count == 9'd0) || (count > free_total_q)) begin
								status_d = 1'b1;
								state_d = dca_pkg::ST_FINISH;
							end else begin
								head_d = free_head_q[7:0];
								slot_d = head_slot;
								mem_req.rd_en = 1'b1;
								mem_req.rd_addr = head_slot;
								state_d = dca_pkg::ST_WALK;
							end
						end
						dca_pkg::MODE_RECLAIM, dca_pkg::MODE_QUERY, dca_pkg::MODE_SET: begin
							if (index >= {7'd0, qs_q}) begin
								status_d = 1'b1;
								state_d = dca_pkg::ST_FINISH;
							end else begin
								slot_d = index[dca_pkg::SLOT_W-1:0];
								mem_req.rd_en = 1'b1;
								mem_req.rd_addr = index[dca_pkg::SLOT_W-1:0];
								state_d = dca_pkg::ST_WALK;
							end
						end
						default: begin
							state_d = dca_pkg::ST_FINISH;
						end
					endcase
				end
			end
			dca_pkg::ST_WALK: begin
				mem_req.wr_en = 1'b1;
				unique case (mode_q)
					dca_pkg::MODE_ALLOC: begin
						mem_req.wr_flag = more ? dca_pkg::DESC_NEXT : 16'd0;
						mem_req.wr_next = more ? mem_rd.next : 16'd0;
						free_total_d = free_total_q - 9'd1;
						if (more) begin
							remain_d = remain_q - 9'd1;
							slot_d = link_slot;
							mem_req.rd_en = 1'b1;
							mem_req.rd_addr = link_slot;
						end else begin
							free_head_d = mem_rd.next;
							state_d = dca_pkg::ST_FINISH;
						end
					end
					dca_pkg::MODE_RECLAIM: begin
						mem_req.wr_flag = 16'd0;
						mem_req.wr_next = free_head_q;
						free_head_d = {8'd0, slot_q};
						if (free_total_q < qs_q) begin
							free_total_d = free_total_q + 9'd1;
						end
						if (stop) begin
							state_d = dca_pkg::ST_FINISH;
						end else begin
							steps_d = steps_q + 9'd1;
							slot_d = mem_rd.next[dca_pkg::SLOT_W-1:0];
							mem_req.rd_en = 1'b1;
							mem_req.rd_addr = mem_rd.next[dca_pkg::SLOT_W-1:0];
						end
					end
					dca_pkg::MODE_QUERY: begin
						mem_req.wr_en = 1'b0;
						next_d = mem_rd.next;
						state_d = dca_pkg::ST_FINISH;
					end
					dca_pkg::MODE_SET: begin
						mem_req.wr_flag = mem_rd.flag | flags_q;
						mem_req.wr_next = mem_rd.next;
						next_d = mem_rd.next;
						fout_d = mem_rd.flag | flags_q;
						state_d = dca_pkg::ST_FINISH;
					end
					default: begin
						mem_req.wr_en = 1'b0;
						state_d = dca_pkg::ST_FINISH;
					end
				endcase
			end
			dca_pkg::ST_FINISH: begin
				if (res_take) begin
					state_d = dca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dca_pkg::ST_IDLE;
			end
		endcase
	end

	`DCA_ASSERT_NOW(a_wr_only_walk, mem_req.wr_en, state_q == dca_pkg::ST_WALK,
		"table write outside a walk")
	`DCA_ASSERT_NOW(a_free_bound, 1'b1, free_total_q <= qs_q,
		"free count above queue size")
	`DCA_ASSERT_NOW(a_rd_in_range, mem_req.rd_en, {1'b0, mem_req.rd_addr} < qs_q,
		"slot read beyond queue size")
	`DCA_ASSERT_NEXT(a_alloc_walks,
		accept && (mode == dca_pkg::MODE_ALLOC) && (count != 9'd0)
		&& (count <= free_total_q),
		state_q == dca_pkg::ST_WALK, "accepted alloc did not start a walk")
	`DCA_ASSERT_NOW(a_reclaim_bound,
		(state_q == dca_pkg::ST_WALK) && (mode_q == dca_pkg::MODE_RECLAIM),
		steps_q < qs_q, "reclaim walk longer than queue")

endmodule

/* tb/descriptor_chain_allocator_tb.sv */
`timescale 1ns / 1ps

module descriptor_chain_allocator_tb;

	typedef struct {
		dca_pkg::mode_t op;
		logic [8:0]     cnt;
		logic [15:0]    idx;
		logic [15:0]    fl;
	} req_item_t;

	localparam int LONG_HOLD = 300;
	localparam int ITEMS_PER_PHASE = 135;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = 2'd0;
	logic [8:0]  count = 9'd0;
	logic [15:0] index = 16'd0;
	logic [15:0] flags = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [7:0]  head_index;
	logic [15:0] next_index;
	logic [15:0] flags_out;
	logic [8:0]  free_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  size_wr = 9'd256;

	logic [15:0] link_tbl [256];
	logic [15:0] flag_tbl [256];
	logic [15:0] m_head;
	int          m_free;
	int          m_size;

	req_item_t     req_q [$];
	dca_pkg::res_t result_q [$];
	logic [7:0]    heads_pool [$];
	req_item_t     cur_req;
	bit            drv_busy = 1'b0;
	bit            req_done = 1'b0;
	int            gap_left = 0;
	int            stall_left = 0;
	int            run_left = 0;
	bit            long_hold_req = 1'b0;
	bit            quiet = 1'b0;
	int            errors = 0;
	int            size_plan [13] = '{2, 256, 3, 16, 4, 0, 64, 511, 128, 8, 32, 256, 2};

	descriptor_chain_allocator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.count      (count),
		.index      (index),
		.flags      (flags),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.head_index (head_index),
		.next_index (next_index),
		.flags_out  (flags_out),
		.free_count (free_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.queue_size (size_wr)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_item_t req(dca_pkg::mode_t op, int cnt, int idx, int fl);
		req_item_t r;
		r.op = op;
		r.cnt = cnt[8:0];
		r.idx = idx[15:0];
		r.fl = fl[15:0];
		return r;
	endfunction

	task automatic rebuild_tables(input int s);
		int i;
		for (i = 0; i < 256; i++) begin
			link_tbl[i] = (i + 1 < s) ? 16'(i + 1) : dca_pkg::END_MARK;
			flag_tbl[i] = 16'h0;
		end
		m_size = s;
		m_head = 16'h0;
		m_free = s;
		heads_pool.delete();
	endtask

	task automatic apply_size(input int v);
		if (v >= 2 && v <= 256 && (v & (v - 1)) == 0)
			rebuild_tables(v);
	endtask

	task automatic track_request(input req_item_t r);
		logic [15:0] mask, cur, slot, link, f;
		int i, steps;
		bit stop;
		dca_pkg::res_t e;
		mask = 16'(m_size - 1);
		e.status = 1'b0;
		e.head = 8'h0;
		e.next = dca_pkg::END_MARK;
		e.flags = 16'h0;
		case (r.op)
			dca_pkg::MODE_ALLOC: begin
				if (r.cnt == 0 || r.cnt > m_free) begin
					e.status = 1'b1;
				end else begin
					cur = m_head;
					e.head = cur[7:0];
					for (i = 0; i < r.cnt; i++) begin
						slot = cur & mask;
						link = link_tbl[slot[7:0]];
						flag_tbl[slot[7:0]] = (i + 1 < r.cnt) ? dca_pkg::DESC_NEXT : 16'h0;
						link_tbl[slot[7:0]] = (i + 1 < r.cnt) ? link : 16'h0;
						cur = link;
					end
					m_head = cur;
					m_free -= r.cnt;
					heads_pool.push_back(e.head);
				end
			end
			dca_pkg::MODE_RECLAIM: begin
				if (r.idx >= m_size) begin
					e.status = 1'b1;
				end else begin
					cur = r.idx;
					stop = 1'b0;
					for (steps = 0; steps < m_size && !stop; steps++) begin
						slot = cur & mask;
						link = link_tbl[slot[7:0]];
						f = flag_tbl[slot[7:0]];
						flag_tbl[slot[7:0]] = 16'h0;
						link_tbl[slot[7:0]] = m_head;
						m_head = slot;
						if (m_free < m_size)
							m_free++;
						if ((f & dca_pkg::DESC_NEXT) == 16'h0 || link >= m_size)
							stop = 1'b1;
						cur = link;
					end
				end
			end
			dca_pkg::MODE_QUERY: begin
				if (r.idx >= m_size)
					e.status = 1'b1;
				else
					e.next = link_tbl[r.idx[7:0]];
			end
			default: begin
				if (r.idx >= m_size) begin
					e.status = 1'b1;
				end else begin
					e.next = link_tbl[r.idx[7:0]];
					flag_tbl[r.idx[7:0]] = flag_tbl[r.idx[7:0]] | r.fl;
					e.flags = flag_tbl[r.idx[7:0]];
				end
			end
		endcase
		e.free = m_free[8:0];
		result_q.push_back(e);
	endtask

	task automatic make_item(output req_item_t r);
		int roll, k, lim;
		roll = $urandom_range(0, 99);
		if (roll >= 35 && roll < 65 && heads_pool.size() == 0)
			roll = 0;
		if (roll < 35) begin
			k = $urandom_range(0, 99);
			lim = (m_free < 6) ? m_free : 6;
			if (k < 85 && lim > 0)
				r = req(dca_pkg::MODE_ALLOC, $urandom_range(1, lim), 0, 0);
			else if (k < 93)
				r = req(dca_pkg::MODE_ALLOC, $urandom_range(1, m_size), 0, 0);
			else if (k < 96)
				r = req(dca_pkg::MODE_ALLOC, 0, 0, 0);
			else
				r = req(dca_pkg::MODE_ALLOC, $urandom_range(m_free + 1, 511), 0, 0);
			r.idx = 16'($urandom);
			r.fl = 16'($urandom);
		end else if (roll < 65) begin
			k = $urandom_range(0, heads_pool.size() - 1);
			r = req(dca_pkg::MODE_RECLAIM, $urandom, int'(heads_pool[k]), $urandom);
			heads_pool.delete(k);
		end else if (roll < 80) begin
			r = req(dca_pkg::MODE_QUERY, $urandom, $urandom_range(0, m_size - 1), $urandom);
			if ($urandom_range(0, 9) == 0)
				r.idx = 16'($urandom);
		end else if (roll < 92) begin
			if (heads_pool.size() > 0 && $urandom_range(0, 1))
				k = int'(heads_pool[$urandom_range(0, heads_pool.size() - 1)]);
			else
				k = $urandom_range(0, m_size - 1);
			r = req(dca_pkg::MODE_SET, $urandom, k, $urandom);
			if ($urandom_range(0, 99) < 85)
				r.fl[0] = 1'b0;
		end else begin
			r = req(dca_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, 511),
				$urandom, $urandom);
		end
	endtask

	task automatic offer(input req_item_t r);
		while (req_q.size() >= 2)
			@(posedge clk);
		req_q.push_back(r);
	endtask

	task automatic drain();
		while (req_q.size() != 0 || drv_busy || result_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_queue_size(input int v);
		@(negedge clk);
		cfg_valid = 1'b1;
		size_wr = v[8:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_size(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		if (req_done) begin
			req_done = 1'b0;
			drv_busy = 1'b0;
		end
		if (!drv_busy) begin
			if (gap_left > 0 || req_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				cur_req = req_q.pop_front();
				mode <= cur_req.op;
				count <= cur_req.cnt;
				index <= cur_req.idx;
				flags <= cur_req.fl;
				in_valid <= 1'b1;
				drv_busy = 1'b1;
				gap_left = quiet ? 0 : idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			track_request(cur_req);
			req_done = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (run_left > 0) begin
				run_left--;
			end else if (!quiet) begin
				stall_left = idle_len();
				run_left = $urandom_range(0, 8);
			end
		end
	end

	always @(posedge clk) begin : result_check
		dca_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("result beat with no request outstanding");
				errors++;
			end else begin
				want = result_q.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0h, actual %0h", want.status, status);
					errors++;
				end
				if (head_index !== want.head) begin
					$error("head_index: expected %0h, actual %0h", want.head, head_index);
					errors++;
				end
				if (next_index !== want.next) begin
					$error("next_index: expected %0h, actual %0h", want.next, next_index);
					errors++;
				end
				if (flags_out !== want.flags) begin
					$error("flags_out: expected %0h, actual %0h", want.flags, flags_out);
					errors++;
				end
				if (free_count !== want.free) begin
					$error("free_count: expected %0h, actual %0h", want.free, free_count);
					errors++;
				end
			end
		end
	end

	initial begin
		req_item_t it;
		int p, n;
		rebuild_tables(256);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer(req(dca_pkg::MODE_QUERY, 0, 0, 0));
		offer(req(dca_pkg::MODE_QUERY, 0, 255, 0));
		offer(req(dca_pkg::MODE_QUERY, 0, 256, 0));
		offer(req(dca_pkg::MODE_QUERY, 511, 16'hffff, 16'hffff));
		offer(req(dca_pkg::MODE_ALLOC, 0, 0, 0));
		offer(req(dca_pkg::MODE_ALLOC, 257, 0, 0));
		offer(req(dca_pkg::MODE_ALLOC, 511, 16'hffff, 16'hffff));
		offer(req(dca_pkg::MODE_ALLOC, 3, 0, 0));
		offer(req(dca_pkg::MODE_SET, 0, 2, 0));
		offer(req(dca_pkg::MODE_SET, 0, 1, 16'h8000));
		offer(req(dca_pkg::MODE_RECLAIM, 0, 0, 0));
		offer(req(dca_pkg::MODE_RECLAIM, 0, 256, 0));
		offer(req(dca_pkg::MODE_RECLAIM, 0, 16'hffff, 0));
		offer(req(dca_pkg::MODE_ALLOC, 256, 0, 0));
		offer(req(dca_pkg::MODE_ALLOC, 1, 0, 0));
		offer(req(dca_pkg::MODE_QUERY, 0, 255, 0));
		offer(req(dca_pkg::MODE_SET, 0, 255, 16'hffff));
		offer(req(dca_pkg::MODE_RECLAIM, 0, 2, 0));
		offer(req(dca_pkg::MODE_SET, 0, 7, dca_pkg::DESC_NEXT));
		offer(req(dca_pkg::MODE_RECLAIM, 0, 7, 0));
		offer(req(dca_pkg::MODE_QUERY, 0, 7, 0));
		offer(req(dca_pkg::MODE_ALLOC, 4, 0, 0));
		offer(req(dca_pkg::MODE_SET, 0, 0, 16'haaaa));
		offer(req(dca_pkg::MODE_SET, 0, 0, 16'h5555));
		offer(req(dca_pkg::MODE_QUERY, 0, 0, 0));
		drain();

		for (p = 0; p < 13; p++) begin
			quiet = (p == 1 || p == 6);
			write_queue_size(size_plan[p]);
			if (p == 4)
				long_hold_req = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					drain();
				make_item(it);
				offer(it);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && result_q.size() == 0)
			$display("descriptor_chain_allocator test passed");
		else
			$display("descriptor_chain_allocator test failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("descriptor_chain_allocator test failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dca_pkg.sv
rtl/dca_mem.sv
rtl/dca_ctrl.sv
rtl/descriptor_chain_allocator.sv
tb/descriptor_chain_allocator_tb.sv
